/* rtl/frx_pkg.sv */
package frx_pkg;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_FILL,
		ST_SEND,
		ST_BAD
	} state_t;

	typedef enum logic [1:0] {
		STATUS_GOOD    = 2'd0,
		STATUS_END_ERR = 2'd1,
		STATUS_CHK_ERR = 2'd2
	} status_t;

	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	localparam logic [7:0] START_MARKER_RST = 8'd2;
	localparam logic [7:0] END_MARKER_RST   = 8'd3;

endpackage

/* rtl/frx_ram.sv */
module frx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/fixed_frame_receiver_xor_check_top.sv */
// Fixed-length frame receiver. While hunting, bytes other than the start marker are
// dropped; a start marker opens a frame of FRAME_LEN bytes, taken one per cycle into the
// frame RAM with no resync. On the last byte the frame is judged: a wrong end marker wins
// over a checksum mismatch (XOR of bytes 1..FRAME_LEN-3 against byte FRAME_LEN-2). A good
// frame is then read back out of the frame RAM at one result per cycle while out_ready is
// high, FRAME_LEN results with last_of_frame on the final one; a bad frame gives one status
// result. The frame RAM has a single write and a single read port and is either being filled
// or being read, so no input is taken while results are being delivered. The good and bad
// counters wrap at 16 bits and show their value after the frame was judged.
module fixed_frame_receiver_xor_check_top #(
	parameter int FRAME_LEN = 20
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic [5:0]  byte_index,
	output logic        last_of_frame,
	output logic [1:0]  status,
	output logic [15:0] good_frames,
	output logic [15:0] bad_frames
);

	localparam int ADDR_W = $clog2(FRAME_LEN);
	localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(FRAME_LEN - 1);
	localparam logic [ADDR_W-1:0] POS_CHK  = ADDR_W'(FRAME_LEN - 2);
	localparam logic [ADDR_W-1:0] POS_DATA = ADDR_W'(FRAME_LEN - 3);

	frx_pkg::state_t  state_q, state_d;
	frx_pkg::status_t status_q, judge_status;

	logic [7:0]        start_q, end_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        xor_q;
	logic [7:0]        chk_q;
	logic [15:0]       good_q, bad_q;

	logic              in_xfer, out_xfer, frame_done;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_rdata;

	assign in_xfer    = in_valid && in_ready;
	assign out_xfer   = out_valid && out_ready;
	assign frame_done = (state_q == frx_pkg::ST_FILL) && in_xfer && (pos_q == POS_LAST);

	always_comb begin
		if (rx_byte != end_q) begin
			judge_status = frx_pkg::STATUS_END_ERR;
		end else if (xor_q != chk_q) begin
			judge_status = frx_pkg::STATUS_CHK_ERR;
		end else begin
			judge_status = frx_pkg::STATUS_GOOD;
		end
	end

	// next state and frame ram control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(idx_q + 1'b1);
		case (state_q)
			frx_pkg::ST_HUNT: begin
				in_ready  = 1'b1;
				ram_waddr = '0;
				if (in_valid && (rx_byte == start_q)) begin
					ram_we  = 1'b1;
					state_d = frx_pkg::ST_FILL;
				end
			end
			frx_pkg::ST_FILL: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_we = 1'b1;
					if (pos_q == POS_LAST) begin
						if (judge_status == frx_pkg::STATUS_GOOD) begin
							// prefetch byte zero so it is on the output next cycle
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_d   = frx_pkg::ST_SEND;
						end else begin
							state_d = frx_pkg::ST_BAD;
						end
					end
				end
			end
			frx_pkg::ST_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (idx_q == POS_LAST) begin
						state_d = frx_pkg::ST_HUNT;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			frx_pkg::ST_BAD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = frx_pkg::ST_HUNT;
				end
			end
			default: begin
				state_d = frx_pkg::ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frx_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= frx_pkg::START_MARKER_RST;
			end_q   <= frx_pkg::END_MARKER_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				frx_pkg::REG_START_MARKER: start_q <= cfg_data;
				frx_pkg::REG_END_MARKER:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			idx_q    <= '0;
			xor_q    <= '0;
			chk_q    <= '0;
			status_q <= frx_pkg::STATUS_GOOD;
			good_q   <= '0;
			bad_q    <= '0;
		end else begin
			if ((state_q == frx_pkg::ST_HUNT) && in_xfer && (rx_byte == start_q)) begin
				pos_q <= ADDR_W'(1);
				xor_q <= '0;
			end
			if ((state_q == frx_pkg::ST_FILL) && in_xfer) begin
				pos_q <= ADDR_W'(pos_q + 1'b1);
				if (pos_q <= POS_DATA) begin
					xor_q <= xor_q ^ rx_byte;
				end
				if (pos_q == POS_CHK) begin
					chk_q <= rx_byte;
				end
			end
			if (frame_done) begin
				pos_q    <= '0;
				idx_q    <= '0;
				status_q <= judge_status;
				if (judge_status == frx_pkg::STATUS_GOOD) begin
					good_q <= good_q + 16'd1;
				end else begin
					bad_q <= bad_q + 16'd1;
				end
			end
			if ((state_q == frx_pkg::ST_SEND) && out_xfer) begin
				idx_q <= ADDR_W'(idx_q + 1'b1);
			end
		end
	end

	frx_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_LEN)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ram read data is held between transfers, so it serves as the output register
	assign frame_byte    = (state_q == frx_pkg::ST_SEND) ? ram_rdata : 8'd0;
	assign byte_index    = (state_q == frx_pkg::ST_SEND) ? 6'(idx_q) : 6'd0;
	assign last_of_frame = (state_q == frx_pkg::ST_BAD) ||
		((state_q == frx_pkg::ST_SEND) && (idx_q == POS_LAST));
	assign status        = status_q;
	assign good_frames   = good_q;
	assign bad_frames    = bad_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open at once");

	a_good_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(good_q) |-> (state_q == frx_pkg::ST_SEND) &&
			($past(state_q) == frx_pkg::ST_FILL))
		else $error("good count moved outside a good frame judgment");

	a_bad_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bad_q) |-> (state_q == frx_pkg::ST_BAD) &&
			($past(state_q) == frx_pkg::ST_FILL))
		else $error("bad count moved outside a bad frame judgment");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frx_pkg::ST_SEND) |-> (idx_q <= POS_LAST))
		else $error("readout index past frame end");

endmodule

/* bench/tb_fixed_frame_receiver_xor_check_top.sv */
module tb_fixed_frame_receiver_xor_check_top;

	localparam int FRAME_LEN = 20;
	localparam int SETTLE_CYCLES = 2 * FRAME_LEN + 10;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int FRAMES_PER_PHASE = 2;

	typedef struct packed {
		logic [7:0]       data;
		logic [5:0]       pos;
		logic             last;
		frx_pkg::status_t st;
		logic [15:0]      good;
		logic [15:0]      bad;
	} frame_result_t;

	typedef struct packed {
		logic             has_noise;
		logic [7:0]       noise;
		logic [7:0]       fill;
		logic             bad_end;
		logic             bad_sum;
		logic             typed;
		frx_pkg::status_t exp_st;
		logic [15:0]      exp_good;
		logic [15:0]      exp_bad;
	} plan_row_t;

	// constant-fill frames; typed rows carry their status result, the rest go through the predictor
	localparam plan_row_t DIRECTED_PLAN [6] = '{
		'{1'b1, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1, frx_pkg::STATUS_END_ERR, 16'd0, 16'd1},
		'{1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, frx_pkg::STATUS_GOOD,    16'd0, 16'd0},
		'{1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, frx_pkg::STATUS_GOOD,    16'd0, 16'd0},
		'{1'b0, 8'h00, 8'h5A, 1'b0, 1'b1, 1'b1, frx_pkg::STATUS_CHK_ERR, 16'd2, 16'd2},
		'{1'b1, frx_pkg::END_MARKER_RST, 8'hA5, 1'b1, 1'b1, 1'b1,
			frx_pkg::STATUS_END_ERR, 16'd2, 16'd3},
		'{1'b0, 8'h00, frx_pkg::START_MARKER_RST, 1'b0, 1'b0, 1'b0,
			frx_pkg::STATUS_GOOD, 16'd0, 16'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  frame_byte;
	logic [5:0]  byte_index;
	logic        last_of_frame;
	logic [1:0]  status;
	logic [15:0] good_frames;
	logic [15:0] bad_frames;

	fixed_frame_receiver_xor_check_top #(
		.FRAME_LEN(FRAME_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_byte(frame_byte),
		.byte_index(byte_index),
		.last_of_frame(last_of_frame),
		.status(status),
		.good_frames(good_frames),
		.bad_frames(bad_frames)
	);

	// receiver model state
	logic [7:0]  cfg_start = frx_pkg::START_MARKER_RST;
	logic [7:0]  cfg_end = frx_pkg::END_MARKER_RST;
	int          fill_pos = 0;
	logic [7:0]  frame_buf [FRAME_LEN];
	logic [7:0]  xor_acc = 8'h00;
	logic [15:0] good_cnt = 16'd0;
	logic [15:0] bad_cnt = 16'd0;

	frame_result_t frame_results_due [$];
	logic [7:0]    tx_queue [$];
	logic          typed_row = 1'b0;
	logic          mismatch_seen = 1'b0;
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	int            hold_requests = 0;
	int            hold_seen = 0;
	int            hold_left = 0;
	int            quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic frame_result_t make_result(input logic [7:0] data, input logic [5:0] pos,
			input logic last, input frx_pkg::status_t st, input logic [15:0] good,
			input logic [15:0] bad);
		frame_result_t r;
		r.data = data;
		r.pos = pos;
		r.last = last;
		r.st = st;
		r.good = good;
		r.bad = bad;
		return r;
	endfunction

	function automatic void predict_rx_byte(input logic [7:0] b);
		frx_pkg::status_t st;
		if (fill_pos == 0) begin
			if (b == cfg_start) begin
				frame_buf[0] = b;
				xor_acc = 8'h00;
				fill_pos = 1;
			end
			return;
		end
		// no resync: a start marker here is plain data
		frame_buf[fill_pos] = b;
		if (fill_pos <= FRAME_LEN - 3)
			xor_acc ^= b;
		if (fill_pos + 1 < FRAME_LEN) begin
			fill_pos++;
			return;
		end
		fill_pos = 0;
		// end marker error wins over checksum error
		if (frame_buf[FRAME_LEN-1] != cfg_end)
			st = frx_pkg::STATUS_END_ERR;
		else if (xor_acc != frame_buf[FRAME_LEN-2])
			st = frx_pkg::STATUS_CHK_ERR;
		else
			st = frx_pkg::STATUS_GOOD;
		if (st != frx_pkg::STATUS_GOOD) begin
			bad_cnt++;
			if (!typed_row)
				frame_results_due.push_back(make_result(8'h00, 6'd0, 1'b1, st, good_cnt, bad_cnt));
			return;
		end
		good_cnt++;
		if (!typed_row)
			for (int k = 0; k < FRAME_LEN; k++)
				frame_results_due.push_back(make_result(frame_buf[k], 6'(k), k == FRAME_LEN - 1,
					frx_pkg::STATUS_GOOD, good_cnt, bad_cnt));
	endfunction

	function automatic void queue_frame(input logic rand_fill, input logic [7:0] fill,
			input logic bad_end, input logic bad_sum);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 8'h00;
		tx_queue.push_back(cfg_start);
		for (int k = 1; k <= FRAME_LEN - 3; k++) begin
			b = fill;
			if (rand_fill)
				case ($urandom_range(7))
					0: b = cfg_start;
					1: b = cfg_end;
					default: b = 8'($urandom);
				endcase
			sum ^= b;
			tx_queue.push_back(b);
		end
		tx_queue.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
		tx_queue.push_back(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
	endfunction

	function automatic void queue_random_frame();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			tx_queue.push_back(cfg_start);
			repeat (FRAME_LEN - 1) tx_queue.push_back(8'($urandom));
		end else
			queue_frame(1'b1, 8'h00, pick < 20, pick < 15 || (pick >= 20 && pick < 30));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_rx_byte(b);
	endtask

	task automatic send_queued();
		while (tx_queue.size() != 0)
			send_byte(tx_queue.pop_front());
	endtask

	// close any open frame, then let everything drain before the next register write
	task automatic finish_phase();
		while (fill_pos != 0)
			send_byte(8'($urandom));
		in_valid <= 1'b0;
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_markers(input logic [7:0] start_val, input logic [7:0] end_val);
		cfg_write <= 1'b1;
		cfg_index <= frx_pkg::REG_START_MARKER;
		cfg_data <= start_val;
		@(posedge clk);
		cfg_index <= frx_pkg::REG_END_MARKER;
		cfg_data <= end_val;
		@(posedge clk);
		cfg_write <= 1'b0;
		cfg_start = start_val;
		cfg_end = end_val;
	endtask

	initial begin
		plan_row_t row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 6; r++) begin
			row = DIRECTED_PLAN[r];
			if (row.has_noise)
				tx_queue.push_back(row.noise);
			queue_frame(1'b0, row.fill, row.bad_end, row.bad_sum);
			if (row.typed)
				frame_results_due.push_back(make_result(8'h00, 6'd0, 1'b1, row.exp_st,
					row.exp_good, row.exp_bad));
			typed_row = row.typed;
			send_queued();
			typed_row = 1'b0;
		end
		finish_phase();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					write_markers(8'h00, 8'hFF);
					tx_idle_pct = 73;
					rx_stall_pct = 0;
				end
				2: begin
					write_markers(8'hFF, 8'h00);
					tx_idle_pct = 0;
					rx_stall_pct = 73;
				end
				3: begin
					write_markers(8'($urandom), 8'($urandom));
					tx_idle_pct = 11;
					rx_stall_pct = 11;
				end
				default: begin
					// same value opens and closes a frame; receiver holds off to back up the input
					write_markers(8'h7E, 8'h7E);
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					hold_requests++;
				end
			endcase
			repeat (FRAMES_PER_PHASE) begin
				repeat ($urandom_range(2)) tx_queue.push_back(8'($urandom));
				queue_random_frame();
				send_queued();
			end
			finish_phase();
		end

		if (!mismatch_seen && frame_results_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else
			out_ready <= $urandom_range(99) >= rx_stall_pct;
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_results_due.size() == 0) begin
				$error("unexpected transfer: frame_byte %0h byte_index %0d status %0d",
					frame_byte, byte_index, status);
				mismatch_seen = 1'b1;
			end else begin
				want = frame_results_due.pop_front();
				if (frame_byte !== want.data) begin
					$error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
					mismatch_seen = 1'b1;
				end
				if (byte_index !== want.pos) begin
					$error("byte_index: expected %0d, got %0d", want.pos, byte_index);
					mismatch_seen = 1'b1;
				end
				if (last_of_frame !== want.last) begin
					$error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame);
					mismatch_seen = 1'b1;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatch_seen = 1'b1;
				end
				if (good_frames !== want.good) begin
					$error("good_frames: expected %0d, got %0d", want.good, good_frames);
					mismatch_seen = 1'b1;
				end
				if (bad_frames !== want.bad) begin
					$error("bad_frames: expected %0d, got %0d", want.bad, bad_frames);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

/* fixed_frame_receiver_xor_check_top.f */
rtl/frx_pkg.sv
rtl/frx_ram.sv
rtl/fixed_frame_receiver_xor_check_top.sv
bench/tb_fixed_frame_receiver_xor_check_top.sv
